// File: design/rtbc_pkg.sv
// ---------------------------------------------------------------------------
// rtbc_pkg: shared definitions for the region table bounds checker
// Type codes, alignment sizes, register map and the query record that
// travels along the cell chain.
// ---------------------------------------------------------------------------
package rtbc_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_ADDR_BITS   = 31;

    // item function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // region type codes
    localparam logic [2:0] KIND_BYTE   = 3'd0;
    localparam logic [2:0] KIND_WORD   = 3'd1;
    localparam logic [2:0] KIND_DWORD  = 3'd2;
    localparam logic [2:0] KIND_QWORD  = 3'd3;
    localparam logic [2:0] KIND_DOUBLE = 3'd4;

    // element sizes in bytes
    localparam int SIZE_S2 = 2;
    localparam int SIZE_S4 = 4;
    localparam int SIZE_S8 = 8;

    localparam logic [2:0] MASK_S2 = 3'(SIZE_S2 - 1);
    localparam logic [2:0] MASK_S4 = 3'(SIZE_S4 - 1);
    localparam logic [2:0] MASK_S8 = 3'(SIZE_S8 - 1);

    // register map (index = byte address / 4)
    localparam int          PADDR_W      = 3;
    localparam logic [0:0]  REG_LAST_IDX = 1'b0;

    // query record handed from cell to cell
    typedef struct packed {
        logic [31:0] addr;        // start address
        logic [32:0] sum;         // address + offset, 33-bit two's complement
        logic [2:0]  off_low;     // low offset bits for the alignment test
        logic        off_zero;
        logic        span_bad;    // negative offset or negative end of span
        logic        addr_neg;
        logic [2:0]  exp_kind;
        logic        found;
        logic [31:0] size;
        logic [2:0]  kind;
        logic        span_done;
        logic        span_err;
    } rtbc_token_t;

endpackage

// File: design/rtbc_ifs.sv
// ---------------------------------------------------------------------------
// rtbc_ifs: valid/ready channels of the region table bounds checker
// Input channel carries load and query items, output channel query results.
// ---------------------------------------------------------------------------
interface rtbc_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [5:0]  entry_index;
    logic [30:0] region_base;
    logic [30:0] region_end;
    logic [2:0]  region_kind;
    logic [31:0] access_address;
    logic [31:0] access_offset;
    logic [2:0]  expected_kind;

    modport source (
        output valid, func, entry_index, region_base, region_end, region_kind,
               access_address, access_offset, expected_kind,
        input  ready
    );
    modport sink (
        input  valid, func, entry_index, region_base, region_end, region_kind,
               access_address, access_offset, expected_kind,
        output ready
    );
endinterface

interface rtbc_out_if;
    logic        valid;
    logic        ready;
    logic        bounds_error;
    logic        region_found;
    logic [31:0] region_size;
    logic [2:0]  found_kind;
    logic        kind_mismatch;

    modport source (
        output valid, bounds_error, region_found, region_size, found_kind,
               kind_mismatch,
        input  ready
    );
    modport sink (
        input  valid, bounds_error, region_found, region_size, found_kind,
               kind_mismatch,
        output ready
    );
endinterface

// File: design/region_table_bounds_checker_top.sv
// ---------------------------------------------------------------------------
// region_table_bounds_checker_top: region table with bounds/type check
// Keeps TABLE_DEPTH regions in a row of cells; a query walks the row one cell
// per cycle unless stalled, picking up the first matching region on the way.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake            carries
//  --------  ---  -------------------  ------------------------------------
//  in_ch     in   valid/ready          load (func 0) or query (func 1)
//  out_ch    out  valid/ready          one result per query
//  apb       in   psel/penable/pwrite  last_region_index at byte 0
//
//  A load is written into its cell and gives no result. A query passes
//  from acceptance to result through the prep stage, the register of
//  each cell of the chain and the output register.
//  One query is in the chain at a time; in_ch.ready stays low while it is.
//  A result waiting in the output register does not block new items; only
//  a second result reaching the chain end while it waits stalls the chain.
//  rst_n clears control state; the table is undefined until loaded.
//
module region_table_bounds_checker_top
    import rtbc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ADDR_BITS   = DEF_ADDR_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    rtbc_in_if.sink            in_ch,
    rtbc_out_if.source         out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // configuration
    logic [5:0]       last_idx_reg;
    logic             cfg_sel;
    logic [IDX_W-1:0] scan_limit;

    // control
    logic             busy_reg;
    logic             in_acc;
    logic             load_acc;
    logic             query_acc;
    logic             adv;
    logic             hand_off;

    // prep stage ahead of the chain
    logic             head_valid_reg;
    logic [IDX_W-1:0] head_rem_reg;
    rtbc_token_t      head_tok_reg;
    rtbc_token_t      head_tok_next;
    logic [32:0]      sum_w;

    // chain links, index 0 fed by the prep stage
    logic             link_valid  [TABLE_DEPTH+1];
    logic             link_active [TABLE_DEPTH+1];
    logic [IDX_W-1:0] link_rem    [TABLE_DEPTH+1];
    rtbc_token_t      link_tok    [TABLE_DEPTH+1];

    // output register
    logic             out_valid_reg;
    logic             out_err_reg;
    logic             out_found_reg;
    logic [31:0]      out_size_reg;
    logic [2:0]       out_kind_reg;
    logic             out_mis_reg;
    rtbc_token_t      last_tok;

    // ---------------- APB register ----------------
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[2:2] == REG_LAST_IDX);
    assign prdata  = cfg_sel ? {26'd0, last_idx_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_idx_reg <= 6'd0;
        end
        else if (psel && penable && pwrite && pready && cfg_sel)
        begin
            last_idx_reg <= pwdata[5:0];
        end
    end

    // last index beyond the table saturates to the last entry
    assign scan_limit = (32'(last_idx_reg) >= TABLE_DEPTH) ? IDX_W'(TABLE_DEPTH - 1)
                                                           : IDX_W'(last_idx_reg);

    // ---------------- input side ----------------
    assign in_ch.ready = !busy_reg;
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign load_acc    = in_acc && (in_ch.func == FUNC_LOAD);
    assign query_acc   = in_acc && (in_ch.func == FUNC_QUERY);

    // a finished result moves on unless the output register is still full
    assign last_tok = link_tok[TABLE_DEPTH];
    assign hand_off = link_valid[TABLE_DEPTH] && (!out_valid_reg || out_ch.ready);
    assign adv      = !(link_valid[TABLE_DEPTH] && out_valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (query_acc)
        begin
            busy_reg <= 1'b1;
        end
        else if (hand_off)
        begin
            busy_reg <= 1'b0;
        end
    end

    // query prep: span end and sign tests, record starts empty
    assign sum_w = {in_ch.access_address[31], in_ch.access_address}
                 + {in_ch.access_offset[31], in_ch.access_offset};

    always_comb
    begin
        head_tok_next           = '0;
        head_tok_next.addr      = in_ch.access_address;
        head_tok_next.sum       = sum_w;
        head_tok_next.off_low   = in_ch.access_offset[2:0];
        head_tok_next.off_zero  = (in_ch.access_offset == 32'd0);
        head_tok_next.span_bad  = in_ch.access_offset[31] || sum_w[32];
        head_tok_next.addr_neg  = in_ch.access_address[31];
        head_tok_next.exp_kind  = in_ch.expected_kind;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            head_valid_reg <= query_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && query_acc)
        begin
            head_tok_reg <= head_tok_next;
            head_rem_reg <= scan_limit;
        end
    end

    assign link_valid[0]  = head_valid_reg;
    assign link_active[0] = 1'b1;
    assign link_rem[0]    = head_rem_reg;
    assign link_tok[0]    = head_tok_reg;

    // ---------------- cell chain ----------------
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic wr_en;

        // loads past the table end hit no cell
        assign wr_en = load_acc && (32'(in_ch.entry_index) == i);

        rtbc_cell #(
            .ADDR_BITS (ADDR_BITS),
            .IDX_W     (IDX_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .wr_en      (wr_en),
            .wr_base    (ADDR_BITS'(in_ch.region_base)),
            .wr_end     (ADDR_BITS'(in_ch.region_end)),
            .wr_kind    (in_ch.region_kind),
            .in_valid   (link_valid[i]),
            .in_active  (link_active[i]),
            .in_rem     (link_rem[i]),
            .in_tok     (link_tok[i]),
            .out_valid  (link_valid[i+1]),
            .out_active (link_active[i+1]),
            .out_rem    (link_rem[i+1]),
            .out_tok    (link_tok[i+1])
        );
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (hand_off)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hand_off)
        begin
            // no deciding entry means the span check fails
            out_err_reg   <= !last_tok.span_done || last_tok.span_err;
            out_found_reg <= last_tok.found;
            out_size_reg  <= last_tok.size;
            out_kind_reg  <= last_tok.kind;
            out_mis_reg   <= !last_tok.found || (last_tok.kind != last_tok.exp_kind);
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.bounds_error  = out_err_reg;
    assign out_ch.region_found  = out_found_reg;
    assign out_ch.region_size   = out_size_reg;
    assign out_ch.found_kind    = out_kind_reg;
    assign out_ch.kind_mismatch = out_mis_reg;

endmodule

// File: design/rtbc_cell.sv
// ---------------------------------------------------------------------------
// rtbc_cell: one table entry plus one stage of the query chain
// Holds base/end/type of its region, tests the passing query against it
// and registers the updated record for the next cell.
// ---------------------------------------------------------------------------
module rtbc_cell
    import rtbc_pkg::*;
#(
    parameter int ADDR_BITS = DEF_ADDR_BITS,
    parameter int IDX_W     = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_base,
    input  logic [ADDR_BITS-1:0] wr_end,
    input  logic [2:0]           wr_kind,
    input  logic                 in_valid,
    input  logic                 in_active,
    input  logic [IDX_W-1:0]     in_rem,
    input  rtbc_token_t          in_tok,
    output logic                 out_valid,
    output logic                 out_active,
    output logic [IDX_W-1:0]     out_rem,
    output rtbc_token_t          out_tok
);

    localparam int CMP_W = (ADDR_BITS > 33) ? ADDR_BITS : 33;
    localparam int SZ_W  = (ADDR_BITS + 1 > 32) ? ADDR_BITS + 1 : 32;

    logic [ADDR_BITS-1:0] base_reg;
    logic [ADDR_BITS-1:0] end_reg;
    logic [2:0]           kind_reg;

    logic                 valid_reg;
    logic                 active_reg;
    logic [IDX_W-1:0]     rem_reg;
    rtbc_token_t          tok_reg;
    rtbc_token_t          tok_next;

    logic [CMP_W-1:0]     addr_c;
    logic [CMP_W-1:0]     sum_c;
    logic [CMP_W-1:0]     base_c;
    logic [CMP_W-1:0]     end_c;
    logic [SZ_W-1:0]      size_full;
    logic                 above_base;
    logic                 contains;
    logic                 span_in;

    assign addr_c     = CMP_W'(in_tok.addr);
    assign sum_c      = CMP_W'(in_tok.sum);
    assign base_c     = CMP_W'(base_reg);
    assign end_c      = CMP_W'(end_reg);
    assign size_full  = SZ_W'(end_reg) - SZ_W'(base_reg) + SZ_W'(1);

    assign above_base = !in_tok.addr_neg && (addr_c >= base_c);
    assign contains   = above_base && (addr_c <= end_c);
    assign span_in    = above_base && !in_tok.span_bad && (sum_c <= end_c);

    always_comb
    begin
        tok_next = in_tok;
        if (in_active)
        begin
            if (!in_tok.found && contains)
            begin
                tok_next.found = 1'b1;
                tok_next.size  = size_full[31:0];
                tok_next.kind  = kind_reg;
            end
            if (!in_tok.span_done && span_in)
            begin
                if (in_tok.off_zero)
                begin
                    tok_next.span_done = 1'b1;
                    tok_next.span_err  = 1'b0;
                end
                else
                begin
                    case (kind_reg)
                        KIND_BYTE:
                        begin
                            tok_next.span_done = 1'b1;
                            tok_next.span_err  = 1'b0;
                        end
                        KIND_WORD:
                        begin
                            tok_next.span_done = 1'b1;
                            tok_next.span_err  = |(in_tok.off_low & MASK_S2);
                        end
                        KIND_DWORD:
                        begin
                            tok_next.span_done = 1'b1;
                            tok_next.span_err  = |(in_tok.off_low & MASK_S4);
                        end
                        KIND_QWORD, KIND_DOUBLE:
                        begin
                            tok_next.span_done = 1'b1;
                            tok_next.span_err  = |(in_tok.off_low & MASK_S8);
                        end
                        default:
                        begin
                            // other types: skipped, scan goes on
                            tok_next.span_done = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    // table entry, undefined until loaded
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            base_reg <= wr_base;
            end_reg  <= wr_end;
            kind_reg <= wr_kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            active_reg <= in_active && (in_rem != '0);
            rem_reg    <= in_rem - IDX_W'(1);
            tok_reg    <= tok_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_active = active_reg;
    assign out_rem    = rem_reg;
    assign out_tok    = tok_reg;

endmodule
